// ===== sv/skf_pkg.sv =====
// ----------------------------------------------------------------------------
// skf_pkg: shared definitions for the scalar kalman filter
// Fixed-point widths, reset values and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

    // fixed-point widths
    localparam int unsigned MEAS_W  = 16;
    localparam int unsigned Q_W     = 32;
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned GAIN_W  = 17;
    localparam int unsigned DIV_W   = Q_W + 1;
    localparam int unsigned CFG_IDX_W = 2;

    // one in q16.16 and in the q1.16 gain
    localparam logic [Q_W-1:0]    ONE_Q16   = 32'h0001_0000;
    localparam logic [GAIN_W-1:0] ONE_GAIN  = 17'h1_0000;
    localparam logic [Q_W-1:0]    Q_MAX     = 32'hFFFF_FFFF;

    // reset values
    localparam logic [Q_W-1:0] PROC_NOISE_RST = 32'h0000_0000;
    localparam logic [Q_W-1:0] MEAS_NOISE_RST = ONE_Q16;
    localparam logic [Q_W-1:0] MEAS_NOISE_MIN = 32'h0000_0001;
    localparam logic [Q_W-1:0] EST_RST        = 32'h0000_0000;
    localparam logic [Q_W-1:0] COV_RST        = ONE_Q16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 2'd1;

endpackage

`default_nettype wire

// ===== sv/skf_divider.sv =====
// ----------------------------------------------------------------------------
// skf_divider: restoring divider for the kalman gain
// Forms floor(numer * 2^16 / denom) one quotient bit per cycle; numer < denom.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_divider
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [skf_pkg::Q_W-1:0]        numer,
    input  wire logic [skf_pkg::DIV_W-1:0]      denom,
    output logic                                done,
    output logic [skf_pkg::FRAC_W-1:0]          quot
);

    typedef enum logic [0:0] {
        DIV_IDLE,
        DIV_RUN
    } div_state_t;

    localparam int unsigned CNT_W = $clog2(skf_pkg::FRAC_W);

    div_state_t                     state_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic [skf_pkg::DIV_W-1:0]      rem_reg;
    logic [skf_pkg::DIV_W-1:0]      den_reg;
    logic [skf_pkg::FRAC_W-1:0]     quot_reg;
    logic                           done_reg;

    logic [skf_pkg::DIV_W:0]        rem_shift;
    logic [skf_pkg::DIV_W:0]        rem_diff;
    logic                           bit_set;
    logic [skf_pkg::DIV_W-1:0]      rem_next;
    logic [skf_pkg::FRAC_W-1:0]     quot_next;

    // one shift, compare and subtract step
    always_comb
    begin
        rem_shift = {rem_reg, 1'b0};
        rem_diff  = rem_shift - {1'b0, den_reg};
        bit_set   = (rem_shift >= {1'b0, den_reg});
        rem_next  = bit_set ? rem_diff[skf_pkg::DIV_W-1:0] : rem_shift[skf_pkg::DIV_W-1:0];
        quot_next = {quot_reg[skf_pkg::FRAC_W-2:0], bit_set};
    end

    // step sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                DIV_IDLE:
                begin
                    if (start)
                    begin
                        cnt_reg   <= CNT_W'(skf_pkg::FRAC_W - 1);
                        state_reg <= DIV_RUN;
                    end
                end
                DIV_RUN:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= DIV_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= DIV_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == DIV_IDLE && start)
        begin
            rem_reg  <= {1'b0, numer};
            den_reg  <= denom;
            quot_reg <= '0;
        end
        else if (state_reg == DIV_RUN)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// ===== sv/scalar_kalman_filter_top.sv =====
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top: one-dimensional kalman filter
// Predicts covariance, forms the gain, updates estimate and covariance.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: measurement with in_valid / in_stall. A transfer happens
//   at a rising edge with in_valid high and in_stall low. in_stall is high
//   while a measurement is being processed.
//   Output channel: estimate and gain with out_valid / out_stall. The result
//   sits in an output register until the receiver takes it.
//   Configuration: cfg_write, cfg_index, cfg_data; register 0 is process
//   noise, register 1 measurement noise (a zero write stores one LSB).
//   Indexes above 1 are ignored. Write only while the filter is idle.
//   Timing: a new measurement is taken only after the previous result has
//   moved into the output register and the sequencer is idle again. The
//   processing time is set by the gain divider, which yields one quotient
//   bit per cycle, plus two passes through the shared multiplier.
//   When the receiver stalls with a result still pending, the next item
//   is accepted and computed, then holds until the output register frees.
//   Reset: estimate 0, covariance one, process noise 0, measurement noise
//   one; no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_filter_top
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration port
    input  wire logic                               cfg_write,
    input  wire logic [skf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [skf_pkg::Q_W-1:0]            cfg_data,
    // input channel
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [skf_pkg::MEAS_W-1:0]         measurement,
    // output channel
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [skf_pkg::Q_W-1:0]                 estimate,
    output logic [skf_pkg::GAIN_W-1:0]              gain
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_MUL_EST,
        ST_MUL_COV,
        ST_COV_WB,
        ST_OUT
    } state_t;

    localparam int unsigned PROD_W = skf_pkg::GAIN_W + skf_pkg::Q_W;

    state_t                             state_reg;
    logic [skf_pkg::Q_W-1:0]            proc_noise_reg;
    logic [skf_pkg::Q_W-1:0]            meas_noise_reg;
    logic [skf_pkg::Q_W-1:0]            est_reg;
    logic [skf_pkg::Q_W-1:0]            cov_reg;
    logic [skf_pkg::Q_W-1:0]            pcov_reg;
    logic [skf_pkg::Q_W-1:0]            diff_reg;
    logic                               neg_reg;
    logic [skf_pkg::GAIN_W-1:0]         gain_reg;
    logic [skf_pkg::Q_W-1:0]            prod_reg;
    logic                               out_valid_reg;
    logic [skf_pkg::Q_W-1:0]            out_est_reg;
    logic [skf_pkg::GAIN_W-1:0]         out_gain_reg;

    logic                               in_xfer;
    logic                               out_free;
    logic [skf_pkg::DIV_W-1:0]          pcov_sum;
    logic [skf_pkg::Q_W-1:0]            pcov_next;
    logic [skf_pkg::Q_W-1:0]            z_val;
    logic                               z_below;
    logic [skf_pkg::DIV_W-1:0]          div_den;
    logic                               div_start;
    logic                               div_done;
    logic [skf_pkg::FRAC_W-1:0]         div_quot;
    logic [skf_pkg::GAIN_W-1:0]         mul_a;
    logic [skf_pkg::Q_W-1:0]            mul_b;
    logic [PROD_W-1:0]                  mul_full;

    // handshakes
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // covariance prediction with saturation, measurement difference
    always_comb
    begin
        pcov_sum  = {1'b0, cov_reg} + {1'b0, proc_noise_reg};
        pcov_next = pcov_sum[skf_pkg::Q_W] ? skf_pkg::Q_MAX : pcov_sum[skf_pkg::Q_W-1:0];
        z_val     = {measurement, {skf_pkg::FRAC_W{1'b0}}};
        z_below   = (z_val < est_reg);
    end

    // gain divider
    assign div_start = (state_reg == ST_START);
    assign div_den   = {1'b0, pcov_reg} + {1'b0, meas_noise_reg};

    skf_divider u_divider
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .numer  (pcov_reg),
        .denom  (div_den),
        .done   (div_done),
        .quot   (div_quot)
    );

    // shared multiplier: gain times difference, then one minus gain times covariance
    always_comb
    begin
        if (state_reg == ST_MUL_COV)
        begin
            mul_a = skf_pkg::ONE_GAIN - gain_reg;
            mul_b = pcov_reg;
        end
        else
        begin
            mul_a = gain_reg;
            mul_b = diff_reg;
        end
        mul_full = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // sequencer, state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            proc_noise_reg <= skf_pkg::PROC_NOISE_RST;
            meas_noise_reg <= skf_pkg::MEAS_NOISE_RST;
            est_reg        <= skf_pkg::EST_RST;
            cov_reg        <= skf_pkg::COV_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    skf_pkg::REG_PROC_NOISE:
                    begin
                        proc_noise_reg <= cfg_data;
                    end
                    skf_pkg::REG_MEAS_NOISE:
                    begin
                        meas_noise_reg <= (cfg_data == '0) ? skf_pkg::MEAS_NOISE_MIN : cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // output register: load a new result or release a taken one
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        state_reg <= ST_START;
                    end
                end
                ST_START:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_MUL_EST;
                    end
                end
                ST_MUL_EST:
                begin
                    state_reg <= ST_MUL_COV;
                end
                ST_MUL_COV:
                begin
                    est_reg   <= neg_reg ? (est_reg - prod_reg) : (est_reg + prod_reg);
                    state_reg <= ST_COV_WB;
                end
                ST_COV_WB:
                begin
                    cov_reg   <= prod_reg;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // working payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pcov_reg <= pcov_next;
            neg_reg  <= z_below;
            diff_reg <= z_below ? (est_reg - z_val) : (z_val - est_reg);
        end
        if (state_reg == ST_WAIT && div_done)
        begin
            gain_reg <= {1'b0, div_quot};
        end
        if (state_reg == ST_MUL_EST || state_reg == ST_MUL_COV)
        begin
            prod_reg <= mul_full[skf_pkg::FRAC_W +: skf_pkg::Q_W];
        end
        if (state_reg == ST_OUT && out_free)
        begin
            out_est_reg  <= est_reg;
            out_gain_reg <= gain_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign estimate  = out_est_reg;
    assign gain      = out_gain_reg;

endmodule

`default_nettype wire

// ===== test/skf_checker.sv =====
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// skf_checker: scoreboard for the scalar kalman filter
// Follows the configuration port and both channels, keeps its own copy of
// the filter state and noise settings, predicts the estimate and gain of
// every input transfer and compares each output transfer with the oldest
// prediction still owed.
// ----------------------------------------------------------------------------
module skf_checker
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [skf_pkg::Q_W-1:0]       cfg_data,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire logic [skf_pkg::MEAS_W-1:0]    measurement,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic [skf_pkg::Q_W-1:0]       estimate,
    input  wire logic [skf_pkg::GAIN_W-1:0]    gain,
    output int unsigned                        mismatch_count,
    output int unsigned                        results_owed
);

    typedef struct packed {
        logic [skf_pkg::Q_W-1:0]    estimate;
        logic [skf_pkg::Q_W-1:0]    covariance;
        logic [skf_pkg::GAIN_W-1:0] gain;
    } filter_update_t;

    typedef struct packed {
        logic [skf_pkg::Q_W-1:0]    estimate;
        logic [skf_pkg::GAIN_W-1:0] gain;
    } filter_out_t;

    // filter state and noise settings as the block should hold them
    logic [skf_pkg::Q_W-1:0] track_estimate;
    logic [skf_pkg::Q_W-1:0] track_covariance;
    logic [skf_pkg::Q_W-1:0] track_proc_noise;
    logic [skf_pkg::Q_W-1:0] track_meas_noise;

    // estimate and gain of every input transfer not yet delivered
    filter_out_t estimate_gain_q[$];

    // one filter step in 64-bit arithmetic
    function automatic filter_update_t kalman_update(
        input logic [skf_pkg::MEAS_W-1:0] meas,
        input logic [skf_pkg::Q_W-1:0]    est,
        input logic [skf_pkg::Q_W-1:0]    cov,
        input logic [skf_pkg::Q_W-1:0]    q_noise,
        input logic [skf_pkg::Q_W-1:0]    r_noise
    );
        logic [63:0]    p_pred;
        logic [63:0]    k;
        logic [63:0]    z;
        logic [63:0]    x;
        logic [63:0]    p_next;
        filter_update_t res;
        // predicted covariance saturates at the top of q16.16
        p_pred = {32'd0, cov} + {32'd0, q_noise};
        if (p_pred > {32'd0, skf_pkg::Q_MAX})
            p_pred = {32'd0, skf_pkg::Q_MAX};
        k = (p_pred << skf_pkg::FRAC_W) / (p_pred + {32'd0, r_noise});
        if (k > 64'(skf_pkg::ONE_GAIN))
            k = 64'(skf_pkg::ONE_GAIN);
        // correction truncated towards the prior estimate
        z = {32'd0, meas, 16'd0};
        x = {32'd0, est};
        if (z >= x)
            x = x + ((k * (z - x)) >> skf_pkg::FRAC_W);
        else
            x = x - ((k * (x - z)) >> skf_pkg::FRAC_W);
        p_next = ((64'(skf_pkg::ONE_GAIN) - k) * p_pred) >> skf_pkg::FRAC_W;
        res.estimate   = x[skf_pkg::Q_W-1:0];
        res.covariance = p_next[skf_pkg::Q_W-1:0];
        res.gain       = k[skf_pkg::GAIN_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        filter_update_t nxt;
        filter_out_t    want;
        int unsigned    errs;
        errs = 0;
        if (!rst_n)
        begin
            track_estimate   <= skf_pkg::EST_RST;
            track_covariance <= skf_pkg::COV_RST;
            track_proc_noise <= skf_pkg::PROC_NOISE_RST;
            track_meas_noise <= skf_pkg::MEAS_NOISE_RST;
            estimate_gain_q.delete();
            mismatch_count   <= 0;
            results_owed     <= 0;
        end
        else
        begin
            // register writes, zero measurement noise held at one lsb
            if (cfg_write)
            begin
                if (cfg_index == skf_pkg::REG_PROC_NOISE)
                    track_proc_noise <= cfg_data;
                else if (cfg_index == skf_pkg::REG_MEAS_NOISE)
                    track_meas_noise <= (cfg_data == '0) ? skf_pkg::MEAS_NOISE_MIN
                                                         : cfg_data;
            end

            // output transfer against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (estimate_gain_q.size() == 0)
                begin
                    $error("result with none owed: estimate %0h, gain %0h", estimate, gain);
                    errs++;
                end
                else
                begin
                    want = estimate_gain_q.pop_front();
                    if (estimate !== want.estimate)
                    begin
                        $error("estimate mismatch: expected %0h, actual %0h",
                               want.estimate, estimate);
                        errs++;
                    end
                    if (gain !== want.gain)
                    begin
                        $error("gain mismatch: expected %0h, actual %0h", want.gain, gain);
                        errs++;
                    end
                end
            end

            // input transfer advances the filter
            if (in_valid && !in_stall)
            begin
                nxt = kalman_update(measurement, track_estimate, track_covariance,
                                    track_proc_noise, track_meas_noise);
                track_estimate   <= nxt.estimate;
                track_covariance <= nxt.covariance;
                want.estimate    = nxt.estimate;
                want.gain        = nxt.gain;
                estimate_gain_q.push_back(want);
            end

            mismatch_count <= mismatch_count + errs;
            results_owed   <= estimate_gain_q.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// tb_top: testbench for the scalar kalman filter
// Drives measurements in random bursts and gaps under a range of noise
// settings, starting with a short directed run over the extremes, while
// the output side stalls on its own pattern. The checker beside the filter
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_PERIOD = 20;
    localparam int RESET_CYCLES = 6;
    localparam int PHASES = 9;
    localparam int PHASE_ITEMS = 82;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_TAIL = 30;
    localparam int WATCHDOG_LIMIT = 4000;

    // indexes with no register behind them
    localparam logic [skf_pkg::CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [skf_pkg::CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

    typedef enum int unsigned {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } stall_mode_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_write = 1'b0;
    logic [skf_pkg::CFG_IDX_W-1:0] cfg_index = skf_pkg::REG_PROC_NOISE;
    logic [skf_pkg::Q_W-1:0]       cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [skf_pkg::MEAS_W-1:0]    measurement = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [skf_pkg::Q_W-1:0]       estimate;
    logic [skf_pkg::GAIN_W-1:0]    gain;

    int unsigned          mismatch_count;
    int unsigned          results_owed;
    int unsigned          idle_cycles = 0;
    logic                 hold_off_req = 1'b0;
    int                   sensor_level = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    scalar_kalman_filter_top dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .measurement (measurement),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .estimate    (estimate),
        .gain        (gain)
    );

    skf_checker u_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .measurement    (measurement),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .estimate       (estimate),
        .gain           (gain),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // offer one measurement and wait for its transfer, valid left high
    task automatic send_measurement(input logic [skf_pkg::MEAS_W-1:0] m);
        in_valid    <= 1'b1;
        measurement <= m;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // stop offering and wait until every owed result has been taken
    task automatic settle_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    // one register write, enable left high for the next one
    task automatic cfg_put(input logic [skf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [skf_pkg::Q_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // both noise registers, optionally with writes to the unused indexes
    task automatic program_noise(input logic [skf_pkg::Q_W-1:0] q,
                                 input logic [skf_pkg::Q_W-1:0] r,
                                 input bit poke_unused);
        if (poke_unused)
            cfg_put(REG_UNUSED_2, $urandom);
        cfg_put(skf_pkg::REG_PROC_NOISE, q);
        cfg_put(skf_pkg::REG_MEAS_NOISE, r);
        if (poke_unused)
            cfg_put(REG_UNUSED_3, skf_pkg::Q_MAX);
        cfg_write <= 1'b0;
    endtask

    // noise value from a few size classes
    function automatic logic [skf_pkg::Q_W-1:0] noise_of_class(input int unsigned cls);
        case (cls)
            0: return '0;
            1: return $urandom_range(1, 255);
            2: return $urandom_range(256, 32'h0010_0000);
            3: return $urandom;
            default: return skf_pkg::Q_MAX;
        endcase
    endfunction

    // idle length between bursts
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 0;
        if (r < 8)
            return $urandom_range(1, 5);
        return $urandom_range(6, 40);
    endfunction

    // output side stalls on its own pattern, with one long hold-off on request
    initial
    begin : receiver
        stall_mode_t mode;
        int unsigned run;
        int unsigned tick;
        bit          hold_off_done;
        hold_off_done = 1'b0;
        tick = 0;
        @(posedge clk);
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 3));
            run  = $urandom_range(8, 120);
            repeat (run)
            begin
                @(posedge clk);
                if (hold_off_req && !hold_off_done)
                begin
                    hold_off_done = 1'b1;
                    out_stall <= 1'b1;
                    repeat (HOLD_OFF_CYCLES)
                        @(posedge clk);
                end
                tick++;
                case (mode)
                    RX_FREE:  out_stall <= 1'b0;
                    RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:  out_stall <= tick[2];
                endcase
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [skf_pkg::MEAS_W-1:0] m;
        int unsigned                burst;
        int unsigned                gap;
        int unsigned                sent;
        int unsigned                r;
        int                         lvl;

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset noise: equal start, both extremes, steps down and up
        send_measurement(16'h0000);
        send_measurement(16'hFFFF);
        send_measurement(16'hFFFF);
        send_measurement(16'h0000);
        send_measurement(16'h0001);
        send_measurement(16'h8000);
        send_measurement(16'h7FFF);
        settle_results();

        // zero measurement noise is held at one lsb
        program_noise('0, '0, 1'b0);
        send_measurement(16'hFFFF);
        send_measurement(16'h0000);
        send_measurement(16'hAAAA);
        send_measurement(16'h5555);
        settle_results();

        // maximal process noise saturates the covariance
        program_noise(skf_pkg::Q_MAX, skf_pkg::Q_MAX, 1'b0);
        send_measurement(16'hFFFF);
        send_measurement(16'h0000);
        send_measurement(16'hFFFF);
        settle_results();

        program_noise(skf_pkg::Q_MAX, skf_pkg::MEAS_NOISE_MIN, 1'b0);
        send_measurement(16'h1234);
        send_measurement(16'hFFFF);
        settle_results();

        // writes to unused indexes leave the noise alone
        program_noise(skf_pkg::PROC_NOISE_RST, skf_pkg::MEAS_NOISE_RST, 1'b1);
        send_measurement(16'h0000);
        send_measurement(16'hFFFF);
        send_measurement(16'h0064);

        // random phases, each under its own noise setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle_results();
            case (ph)
                0: program_noise('0, '0, 1'b0);
                1: program_noise(skf_pkg::Q_MAX, skf_pkg::Q_MAX, 1'b0);
                2: program_noise(skf_pkg::Q_MAX, skf_pkg::MEAS_NOISE_MIN, 1'b1);
                3: program_noise('0, skf_pkg::Q_MAX, 1'b0);
                default: program_noise(noise_of_class($urandom_range(0, 4)),
                                       noise_of_class($urandom_range(0, 4)), ph == 6);
            endcase
            if (ph == 4)
                hold_off_req <= 1'b1;
            sensor_level = $urandom_range(0, 16'hFFFF);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                burst = $urandom_range(1, 24);
                if (burst > PHASE_ITEMS - sent)
                    burst = PHASE_ITEMS - sent;
                repeat (burst)
                begin
                    // half the time a drifting noisy reading, else uniform, extreme or small
                    r = $urandom_range(0, 19);
                    if (r < 10)
                    begin
                        if (r == 0)
                            sensor_level = $urandom_range(0, 16'hFFFF);
                        sensor_level = sensor_level + int'($urandom_range(0, 200)) - 100;
                        if (sensor_level < 0)
                            sensor_level = 0;
                        if (sensor_level > 16'hFFFF)
                            sensor_level = 16'hFFFF;
                        lvl = sensor_level + int'($urandom_range(0, 64)) - 32;
                        if (lvl < 0)
                            lvl = 0;
                        if (lvl > 16'hFFFF)
                            lvl = 16'hFFFF;
                        m = lvl[skf_pkg::MEAS_W-1:0];
                    end
                    else if (r < 17)
                        m = $urandom;
                    else if (r == 17)
                        m = '0;
                    else if (r == 18)
                        m = 16'hFFFF;
                    else
                        m = $urandom_range(0, 15);
                    send_measurement(m);
                    sent++;
                end
                // some phases run without gaps
                gap = (ph % 3 == 1) ? 0 : pick_gap();
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap)
                        @(posedge clk);
                end
            end
        end

        settle_results();
        repeat (DRAIN_TAIL)
            @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
